FILE: sv/rbd_pkg.sv
// Package for the restoring binary divider: operand width, field width,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package rbd_pkg;

  // Port field width fixed by the item format; operand width used internally.
  localparam int FIELD_W = 64;
  localparam int WIDTH   = 64;
  localparam int CNT_W   = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } rbd_state_t;

  typedef struct packed {
    logic load;   // capture operands, clear partial remainder
    logic step;   // one shift-subtract iteration
    logic store;  // copy finished result into the output register
  } rbd_cmd_t;

endpackage

FILE: sv/rbd_if.sv
// Handshake interfaces for the divider's operand and result channels.
// Depends on rbd_pkg for the field width.
interface rbd_in_if;
  import rbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rbd_out_if;
  import rbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;
  logic               divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface

FILE: sv/restoring_binary_divider.sv
// Restoring binary divider, top level: WIDTH-bit unsigned quotient and remainder.
// The operand beat's edge loads the operands, then WIDTH shift-subtract steps run through
// the single subtractor, and a store copies the result into the output register once
// that register is free.
// Operands are taken only while idle, so a new item waits until the last one is stored; the
// next operand beat is taken while a result beat still waits in the output register.
// Reset (rst_n low, synchronous): controller idle, output valid cleared.
module restoring_binary_divider (
  input  logic      clk,
  input  logic      rst_n,
  rbd_in_if.sink    in_if,
  rbd_out_if.source out_if
);
  import rbd_pkg::*;

  rbd_cmd_t         cmd;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;

  // Controller sequences load, WIDTH steps and store; it owns the handshakes.
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // Only the low WIDTH bits of each operand count; drop the rest.
  // A zero divisor needs no special path: every step subtracts zero, so the
  // quotient fills with ones and the remainder ends as the dividend.
  rbd_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .dividend       (in_if.dividend[WIDTH-1:0]),
    .divisor        (in_if.divisor[WIDTH-1:0]),
    .quotient       (quo),
    .remainder      (rem),
    .divide_by_zero (out_if.divide_by_zero)
  );

  // Zero-extend results to the field width.
  assign out_if.quotient  = FIELD_W'(quo);
  assign out_if.remainder = FIELD_W'(rem);

endmodule

FILE: sv/rbd_ctrl.sv
// Divider controller: state machine, step counter and output valid flag.
// Depends on rbd_pkg for state and command types.
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rbd_pkg::rbd_cmd_t cmd
);
  import rbd_pkg::*;

  rbd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step;
  logic             out_free;

  assign last_step = (cnt_r == CNT_W'(WIDTH - 1));
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (last_step) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN:  cmd.step  = 1'b1;
      ST_FIN:  cmd.store = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) cnt_nxt = '0;
    else if (cmd.step) cnt_nxt = cnt_r + CNT_W'(1);
    out_valid_nxt = out_valid_r;
    if (cmd.store) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("load did not start a run at step zero");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !last_step |=> (state_r == ST_RUN))
    else $error("run left before the last step");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> out_valid_r)
    else $error("stored result not presented");

  a_store_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

FILE: sv/rbd_datapath.sv
// Divider datapath: partial remainder, shifting dividend/quotient register,
// one WIDTH+1 bit subtractor, and the output result register.
// Depends on rbd_pkg for WIDTH and the command struct.
module rbd_datapath (
  input  logic                           clk,
  input  rbd_pkg::rbd_cmd_t              cmd,
  input  logic [rbd_pkg::WIDTH-1:0]      dividend,
  input  logic [rbd_pkg::WIDTH-1:0]      divisor,
  output logic [rbd_pkg::WIDTH-1:0]      quotient,
  output logic [rbd_pkg::WIDTH-1:0]      remainder,
  output logic                           divide_by_zero
);
  import rbd_pkg::*;

  logic [WIDTH-1:0] den_r;
  logic [WIDTH-1:0] part_r, part_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;   // dividend bits shift out, quotient bits shift in
  logic             dbz_r;
  logic [WIDTH-1:0] out_quo_r, out_rem_r;
  logic             out_dbz_r;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH:0]   diff;
  logic             take;

  // bring down the next dividend bit; the carry out of the old remainder
  // forms the top bit of a WIDTH+1 bit partial remainder
  assign shifted = {part_r[WIDTH-2:0], quo_r[WIDTH-1]};
  assign diff    = {part_r[WIDTH-1], shifted} - {1'b0, den_r};
  assign take    = part_r[WIDTH-1] || !diff[WIDTH];

  always_comb begin
    part_nxt = take ? diff[WIDTH-1:0] : shifted;
    quo_nxt  = {quo_r[WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r  <= divisor;
      part_r <= '0;
      quo_r  <= dividend;
      dbz_r  <= (divisor == '0);
    end else if (cmd.step) begin
      part_r <= part_nxt;
      quo_r  <= quo_nxt;
    end
    if (cmd.store) begin
      out_quo_r <= quo_r;
      out_rem_r <= part_r;
      out_dbz_r <= dbz_r;
    end
  end

  assign quotient       = out_quo_r;
  assign remainder      = out_rem_r;
  assign divide_by_zero = out_dbz_r;

endmodule

FILE: tb/sv/rbd_quotient_checker.sv
`timescale 1ns / 100ps
// Watches the divider's operand and result channels and predicts each quotient and remainder.
// Compares every result beat with the oldest expected one. Depends on rbd_pkg and rbd_if.
module rbd_quotient_checker (
  input  logic        clk,
  input  logic        rst_n,
  rbd_in_if           in_mon,
  rbd_out_if          out_mon,
  output int unsigned err_cnt,
  output int unsigned outstanding,
  output int unsigned results_seen,
  output int unsigned zero_div_seen
);
  import rbd_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               divide_by_zero;
  } quo_rem_t;

  quo_rem_t pending_quotients[$];

  // Shift-subtract long division on WIDTH-bit operands; bits above WIDTH are dropped.
  function automatic quo_rem_t divide_restoring(input logic [FIELD_W-1:0] dividend,
                                                input logic [FIELD_W-1:0] divisor);
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    logic [WIDTH-1:0] quo;
    logic [WIDTH:0]   part;
    quo_rem_t         res;
    num  = dividend[WIDTH-1:0];
    den  = divisor[WIDTH-1:0];
    res  = '0;
    part = '0;
    quo  = '0;
    if (den == '0) begin
      res.quotient[WIDTH-1:0]  = '1;
      res.remainder[WIDTH-1:0] = num;
      res.divide_by_zero       = 1'b1;
      return res;
    end
    for (int i = WIDTH - 1; i >= 0; i--) begin
      part = {part[WIDTH-1:0], num[i]};
      quo  = quo << 1;
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    res.quotient[WIDTH-1:0]  = quo;
    res.remainder[WIDTH-1:0] = part[WIDTH-1:0];
    return res;
  endfunction

  int unsigned errs;
  int unsigned seen;
  int unsigned zdiv;
  quo_rem_t    exp_res;

  initial begin
    errs = 0;
    seen = 0;
    zdiv = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        pending_quotients.push_back(divide_restoring(in_mon.dividend, in_mon.divisor));
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (out_mon.divide_by_zero) zdiv++;
        if (pending_quotients.size() == 0) begin
          errs++;
          $error("result beat with nothing expected: quotient %h remainder %h",
                 out_mon.quotient, out_mon.remainder);
        end else begin
          exp_res = pending_quotients.pop_front();
          if (out_mon.quotient !== exp_res.quotient) begin
            errs++;
            $error("quotient mismatch: expected %h, actual %h",
                   exp_res.quotient, out_mon.quotient);
          end
          if (out_mon.remainder !== exp_res.remainder) begin
            errs++;
            $error("remainder mismatch: expected %h, actual %h",
                   exp_res.remainder, out_mon.remainder);
          end
          if (out_mon.divide_by_zero !== exp_res.divide_by_zero) begin
            errs++;
            $error("divide_by_zero mismatch: expected %b, actual %b",
                   exp_res.divide_by_zero, out_mon.divide_by_zero);
          end
        end
      end
    end
    err_cnt       <= errs;
    outstanding   <= unsigned'(pending_quotients.size());
    results_seen  <= seen;
    zero_div_seen <= zdiv;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the divider testbench: clock, reset, operand and result-side traffic, verdict.
// Depends on rbd_pkg, rbd_if, the divider and rbd_quotient_checker.
module tb_top;
  import rbd_pkg::*;

  localparam int          RANDOM_ITEMS = 1850;
  localparam int          IDLE_PCT     = 34;
  // Receiver hold-off window, in receiver cycles after reset.
  localparam int          HOLD_START   = 4000;
  localparam int          HOLD_LEN     = 1200;
  // Receiver window with ready held high throughout.
  localparam int          RX_CALM_LO   = 30000;
  localparam int          RX_CALM_HI   = 50000;
  // Operand beats sent back to back, counted over the random part.
  localparam int          TX_CALM_LO   = 900;
  localparam int          TX_CALM_HI   = 1200;
  localparam int          DRAIN_CYCLES = WIDTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  localparam logic [FIELD_W-1:0] ALL_ONES = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT  = {1'b1, {(FIELD_W-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic tx_calm;

  int unsigned beats_sent;
  int unsigned cycle_cnt;
  int unsigned rx_cycle;
  int unsigned err_cnt;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned zero_div_seen;

  rbd_in_if  in_ch ();
  rbd_out_if out_ch ();

  restoring_binary_divider dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  rbd_quotient_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_cnt       (err_cnt),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .zero_div_seen (zero_div_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort on a hang: the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, outstanding);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: drop ready at random, hold it low for one long stretch so the
  // output register and the datapath fill and the operand side stalls, and keep
  // it high through a calm window.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle     <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_ch.ready <= 1'b0;
      end else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random value confined to the low nbits bits (nbits in 1..FIELD_W).
  function automatic logic [FIELD_W-1:0] rand_bits(input int nbits);
    logic [FIELD_W-1:0] v;
    v = rand_word();
    return v >> (FIELD_W - nbits);
  endfunction

  // Offer one operand beat and hold it until the divider takes it. Valid stays
  // high into the next beat unless an idle cycle is inserted.
  task automatic send_operands(input logic [FIELD_W-1:0] dividend,
                               input logic [FIELD_W-1:0] divisor);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= dividend;
    in_ch.divisor  <= divisor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // One random operand pair, biased toward the interesting corners of division.
  task automatic send_random_pair();
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] t;
    int                 pick;
    pick = $urandom_range(99);
    a    = rand_word();
    b    = rand_word();
    if (pick < 28) begin
      // full-width operands on both sides
    end else if (pick < 48) begin
      b = rand_bits($urandom_range(FIELD_W, 1));
    end else if (pick < 62) begin
      a = rand_bits($urandom_range(FIELD_W, 1));
      b = rand_bits($urandom_range(FIELD_W, 1));
    end else if (pick < 72) begin
      // dividend below divisor: swap so a < b
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if (a == b) b = a + 1;
    end else if (pick < 80) begin
      // divisor close to the dividend, above or below
      t = FIELD_W'($urandom_range(3));
      b = ($urandom_range(1)) ? a + t : a - t;
    end else if (pick < 86) begin
      b = '0;
    end else if (pick < 93) begin
      b = TOP_BIT >> $urandom_range(FIELD_W - 1);
    end else begin
      case ($urandom_range(3))
        0: a = ALL_ONES;
        1: a = TOP_BIT;
        2: b = ALL_ONES - FIELD_W'($urandom_range(3));
        default: b = TOP_BIT | rand_bits($urandom_range(FIELD_W - 1, 1));
      endcase
    end
    send_operands(a, b);
  endtask

  initial begin
    rst_n          = 1'b0;
    tx_calm        = 1'b0;
    beats_sent     = 0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    in_ch.divisor  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero divisor, unit divisor, dividend below, equal to and
    // above the divisor, and divisors with the top bit set so the partial
    // remainder overflows WIDTH bits before the subtract.
    send_operands('0, '0);
    send_operands(ALL_ONES, '0);
    send_operands(64'd12345, '0);
    send_operands('0, 64'd1);
    send_operands(ALL_ONES, 64'd1);
    send_operands('0, ALL_ONES);
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES - 1, ALL_ONES);
    send_operands(64'd1, ALL_ONES);
    send_operands(64'd5, 64'd7);
    send_operands(64'd7, 64'd7);
    send_operands(64'd7, 64'd5);
    send_operands(TOP_BIT, 64'd3);
    send_operands(ALL_ONES, TOP_BIT);
    send_operands(TOP_BIT, TOP_BIT + 1);
    send_operands(ALL_ONES, TOP_BIT + 1);
    send_operands(ALL_ONES, TOP_BIT - 1);
    send_operands(ALL_ONES, 64'hC000_0000_0000_0001);
    send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_operands(64'd3_000_000_023, 64'd3);
    send_operands(ALL_ONES, 64'd2);

    // Random part, with one back-to-back stretch on the operand side.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_calm = (i >= TX_CALM_LO && i < TX_CALM_HI);
      send_random_pair();
    end
    in_ch.valid <= 1'b0;

    // Let the checker's count catch up with the last beat, then drain.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d operand beats sent, %0d results checked (%0d with zero divisor)",
             beats_sent, results_seen, zero_div_seen);
    $display("tb_top: covered unit, zero, top-bit and near-equal divisors under random stalls");
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: restoring_binary_divider.f
sv/rbd_pkg.sv
sv/rbd_if.sv
sv/rbd_ctrl.sv
sv/rbd_datapath.sv
sv/restoring_binary_divider.sv
tb/sv/rbd_quotient_checker.sv
tb/sv/tb_top.sv
